// ===== hw/rtl/lbds_pkg.sv =====
package lbds_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned StepW    = 8;
  localparam int unsigned BarW     = 8;
  localparam int unsigned SegW     = 7;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ThrW     = 13;  // signed, covers centre +/- 4*step

  localparam logic [SampleW-1:0] CentreReset = 10'd871;
  localparam logic [StepW-1:0]   StepReset   = 8'd18;
  localparam logic [SampleW-1:0] Thousand    = 10'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTRE = 2'd0,
    CFG_STEP   = 2'd1
  } cfg_index_e;

  // one queued sample: bar pattern plus its decimal digits, ones first
  typedef struct packed {
    logic [BarW-1:0]                  bar;
    logic [NumDigits-1:0][DigitW-1:0] digits;
  } entry_t;

  // bar level 0 is all on (0x00) ... level 8 is all off (0xFF)
  function automatic logic [BarW-1:0] bar_of_level(input logic [3:0] level);
    logic [15:0] wide;
    wide = 16'hFF00 >> level;
    return wide[BarW-1:0];
  endfunction

  function automatic logic [SegW-1:0] seg_of_digit(input logic [DigitW-1:0] dig);
    logic [SegW-1:0] seg;
    case (dig)
      4'd0: seg = 7'h3f;
      4'd1: seg = 7'h06;
      4'd2: seg = 7'h5b;
      4'd3: seg = 7'h4f;
      4'd4: seg = 7'h66;
      4'd5: seg = 7'h6d;
      4'd6: seg = 7'h7c;
      4'd7: seg = 7'h07;
      4'd8: seg = 7'h7f;
      4'd9: seg = 7'h67;
      default: seg = 7'h3f;
    endcase
    return seg;
  endfunction

endpackage

// ===== hw/rtl/lbds_front.sv =====
module lbds_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lbds_pkg::SampleW-1:0]  centre_i,
  input  logic [lbds_pkg::StepW-1:0]    step_i,
  input  logic                          sample_valid_i,
  output logic                          sample_stall_o,
  input  logic [lbds_pkg::SampleW-1:0]  sample_i,
  output logic                          entry_valid_o,
  input  logic                          entry_stall_i,
  output lbds_pkg::entry_t              entry_o
);
  import lbds_pkg::*;

  logic [BarW-1:0]       bar_q, bar_d;
  logic                  hit_any;
  logic [3:0]            hit_level;
  logic signed [ThrW-1:0] thr;
  logic signed [ThrW-1:0] samp_s;
  logic [ThrW-1:0]       mag;

  logic                  s1_valid_q, s2_valid_q;
  logic                  s1_ready, s2_ready, accept;
  logic [BarW-1:0]       s1_bar_q, s2_bar_q;
  logic                  s1_th_q, s2_th_q;
  logic [SampleW-1:0]    s1_rem_q;
  logic [DigitW-1:0]     s2_hund_q, hund_d, tens_d;
  logic [6:0]            s2_rem_q, rem2_d;
  logic [3:0]            ones_d;

  assign s2_ready       = !s2_valid_q || !entry_stall_i;
  assign s1_ready       = !s1_valid_q || s2_ready;
  assign sample_stall_o = !s1_ready;
  assign accept         = sample_valid_i && s1_ready;

  // threshold ladder: smallest level whose threshold the sample reaches
  always_comb begin
    samp_s    = $signed({3'b000, sample_i});
    hit_any   = 1'b0;
    hit_level = 4'd0;
    for (int k = 8; k >= 0; k--) begin
      mag = ThrW'(step_i) * ThrW'((k < 4) ? (4 - k) : (k - 4));
      if (k < 4) begin
        thr = $signed({3'b000, centre_i}) + $signed(mag);
      end else begin
        thr = $signed({3'b000, centre_i}) - $signed(mag);
      end
      if (samp_s >= thr) begin
        hit_any   = 1'b1;
        hit_level = 4'(k);
      end
    end
    bar_d = hit_any ? bar_of_level(hit_level) : bar_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_q <= '0;
    end else if (accept) begin
      bar_q <= bar_d;
    end
  end

  // hundreds split by parallel compares
  always_comb begin
    hund_d = '0;
    rem2_d = s1_rem_q[6:0];
    for (int j = 1; j <= 9; j++) begin
      if (s1_rem_q >= SampleW'(100 * j)) begin
        hund_d = DigitW'(j);
        rem2_d = 7'(s1_rem_q - SampleW'(100 * j));
      end
    end
  end

  // tens and ones at the queue push
  always_comb begin
    tens_d = '0;
    ones_d = s2_rem_q[3:0];
    for (int j = 1; j <= 9; j++) begin
      if (s2_rem_q >= 7'(10 * j)) begin
        tens_d = DigitW'(j);
        ones_d = 4'(s2_rem_q - 7'(10 * j));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= accept;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bar_q <= bar_d;
      s1_th_q  <= (sample_i >= Thousand);
      s1_rem_q <= (sample_i >= Thousand) ? sample_i - Thousand : sample_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_bar_q  <= s1_bar_q;
      s2_th_q   <= s1_th_q;
      s2_hund_q <= hund_d;
      s2_rem_q  <= rem2_d;
    end
  end

  assign entry_valid_o     = s2_valid_q;
  assign entry_o.bar       = s2_bar_q;
  assign entry_o.digits[0] = ones_d;
  assign entry_o.digits[1] = tens_d;
  assign entry_o.digits[2] = s2_hund_q;
  assign entry_o.digits[3] = {3'b000, s2_th_q};

endmodule

// ===== hw/rtl/lbds_queue.sv =====
module lbds_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_stall_o,
  input  lbds_pkg::entry_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output lbds_pkg::entry_t  pop_data_o
);
  import lbds_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  entry_t            slots_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign push_stall_o = (count_q == Full);
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && !push_stall_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/lbds_back.sv =====
module lbds_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           entry_valid_i,
  output logic                           entry_pop_o,
  input  lbds_pkg::entry_t               entry_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lbds_pkg::SegW-1:0]      segments_o,
  output logic [lbds_pkg::NumDigits-1:0] digit_select_o,
  output logic [lbds_pkg::BarW-1:0]      bar_pattern_o,
  output logic                           last_o
);
  import lbds_pkg::*;

  localparam logic [1:0] LastIdx = 2'(NumDigits - 1);

  entry_t                 cur_q;
  logic                   cur_valid_q, cur_valid_d;
  logic [1:0]             idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free, emit, cur_done;
  logic [SegW-1:0]        seg_q;
  logic [NumDigits-1:0]   sel_q;
  logic [BarW-1:0]        bar_q;
  logic                   last_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit        = out_free && cur_valid_q;
  assign cur_done    = emit && (idx_q == LastIdx);
  assign entry_pop_o = entry_valid_i && (!cur_valid_q || cur_done);

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = cur_valid_q;
    end
    if (emit) begin
      idx_d = idx_q + 1'b1;
    end
    if (cur_done) begin
      cur_valid_d = 1'b0;
    end
    // refill the working entry as soon as it drains
    if (entry_pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o) begin
      cur_q <= entry_i;
    end
    if (emit) begin
      seg_q  <= seg_of_digit(cur_q.digits[idx_q]);
      sel_q  <= NumDigits'(1) << idx_q;
      bar_q  <= cur_q.bar;
      last_q <= (idx_q == LastIdx);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign segments_o     = seg_q;
  assign digit_select_o = sel_q;
  assign bar_pattern_o  = bar_q;
  assign last_o         = last_q;

endmodule

// ===== hw/rtl/light_level_bar_and_digit_scan_core.sv =====
// The ones digit passes the front registers, a queue slot, the working entry and the
// output register. Scan sends one digit per cycle when not stalled, one sample at a time.
// Front end takes a new sample every cycle while the queue has room.
// Reset: centre level 871, step size 18, bar pattern 0x00, front, queue
// and scan stage empty.
module light_level_bar_and_digit_scan_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lbds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lbds_pkg::SampleW-1:0]   cfg_data_i,
  input  logic                           sample_valid_i,
  output logic                           sample_stall_o,
  input  logic [lbds_pkg::SampleW-1:0]   sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lbds_pkg::SegW-1:0]      segments_o,
  output logic [lbds_pkg::NumDigits-1:0] digit_select_o,
  output logic [lbds_pkg::BarW-1:0]      bar_pattern_o,
  output logic                           last_o
);
  import lbds_pkg::*;

  logic [SampleW-1:0] centre_q;
  logic [StepW-1:0]   step_q;
  logic               push_valid, push_stall, pop_valid, pop;
  entry_t             push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= CentreReset;
      step_q   <= StepReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CENTRE: centre_q <= cfg_data_i;
        CFG_STEP:   step_q   <= cfg_data_i[StepW-1:0];
        default:    ;
      endcase
    end
  end

  lbds_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .centre_i       (centre_q),
    .step_i         (step_q),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_i       (sample_i),
    .entry_valid_o  (push_valid),
    .entry_stall_i  (push_stall),
    .entry_o        (push_data)
  );

  lbds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  lbds_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_valid_i  (pop_valid),
    .entry_pop_o    (pop),
    .entry_i        (pop_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_o     (segments_o),
    .digit_select_o (digit_select_o),
    .bar_pattern_o  (bar_pattern_o),
    .last_o         (last_o)
  );

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(digit_select_o))
    else $error("digit select not one-hot");

  a_last_thousands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (digit_select_o == 4'b1000)))
    else $error("last mark not on thousands digit");

  a_scan_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=>
      (out_valid_o && (digit_select_o == ($past(digit_select_o) << 1))))
    else $error("digit scan broke off mid-sample");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("queue popped while empty");

endmodule

// ===== dv/light_level_bar_and_digit_scan_core_tb.sv =====
`timescale 1ns / 100ps

module light_level_bar_and_digit_scan_core_tb;
  import lbds_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ReportLimit = 10;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef struct packed {
    logic [SegW-1:0]      segments;
    logic [NumDigits-1:0] digit_select;
    logic [BarW-1:0]      bar;
    logic                 last;
  } digit_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [SampleW-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [SampleW-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SegW-1:0] segments;
  logic [NumDigits-1:0] digit_select;
  logic [BarW-1:0] bar_pattern;
  logic last;

  // predictor state
  logic [SampleW-1:0] centre_level = CentreReset;
  logic [StepW-1:0] step_size = StepReset;
  logic [BarW-1:0] held_bar = '0;
  digit_frame_t pending_digits[$];

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  light_level_bar_and_digit_scan_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .sample_valid_i (sample_valid),
    .sample_stall_o (sample_stall),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .segments_o     (segments),
    .digit_select_o (digit_select),
    .bar_pattern_o  (bar_pattern),
    .last_o         (last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [SegW-1:0] glyph(input int unsigned dig);
    case (dig)
      0: return 7'h3f;
      1: return 7'h06;
      2: return 7'h5b;
      3: return 7'h4f;
      4: return 7'h66;
      5: return 7'h6d;
      6: return 7'h7c;
      7: return 7'h07;
      8: return 7'h7f;
      default: return 7'h67;
    endcase
  endfunction

  // Walk the ladder from the top threshold down; fall through keeps the held pattern.
  function automatic logic [BarW-1:0] ladder_bar(input logic [SampleW-1:0] value);
    int thr;
    logic [BarW-1:0] ones;
    ones = '1;
    for (int k = 4; k >= -4; k--) begin
      thr = int'(centre_level) + k * int'(step_size);
      if (int'(value) >= thr) return ones << (k + 4);
    end
    return held_bar;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    int k;
    int v;
    if ($urandom_range(2) == 0) return SampleW'($urandom_range(1023));
    // land on or next to a threshold
    k = int'($urandom_range(8)) - 4;
    v = int'(centre_level) + k * int'(step_size) + int'($urandom_range(2)) - 1;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SampleW'(v);
  endfunction

  task automatic set_pacing(input int unsigned idle, input int unsigned stall);
    sender_idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic send_sample(input logic [SampleW-1:0] value);
    digit_frame_t frame;
    int unsigned rest;
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    held_bar = ladder_bar(value);
    rest = value;
    for (int i = 0; i < NumDigits; i++) begin
      frame.segments = glyph(rest % 10);
      frame.digit_select = NumDigits'(1 << i);
      frame.bar = held_bar;
      frame.last = (i == NumDigits - 1);
      pending_digits.push_back(frame);
      rest = rest / 10;
    end
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SampleW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_CENTRE) centre_level = data;
    else if (idx == CFG_STEP) step_size = data[StepW-1:0];
    // drop valid for one cycle so the next write raises it in a later step
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_samples(input int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample());
    wait_drained();
  endtask

  task automatic test_digits_and_ladder();
    logic [SampleW-1:0] picks[$];
    picks = {10'd0, 10'd798, 10'd799, 10'd800, 10'd942, 10'd943, 10'd1023, 10'd798,
             10'd870, 10'd871, 10'd1000, 10'd999, 10'd456, 10'd789, 10'd123, 10'd10,
             10'd9, 10'd100};
    set_pacing(0, 0);
    foreach (picks[i]) send_sample(picks[i]);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    set_pacing(56, 0);
    write_reg(CFG_CENTRE, 10'd0);
    write_reg(CFG_STEP, 10'd0);
    send_sample(10'd0);
    run_samples(30);
    set_pacing(0, 56);
    write_reg(CFG_CENTRE, 10'd1023);
    write_reg(CFG_STEP, 10'd255);
    send_sample(10'd2);
    send_sample(10'd3);
    run_samples(30);
    // negative lower thresholds
    set_pacing(18, 18);
    write_reg(CFG_CENTRE, 10'd0);
    run_samples(30);
    set_pacing(0, 0);
    write_reg(CFG_CENTRE, 10'd1023);
    write_reg(CFG_STEP, 10'd0);
    send_sample(10'd1022);
    send_sample(10'd1023);
    run_samples(30);
    // step keeps its low byte only; spare indexes change nothing
    set_pacing(56, 0);
    write_reg(CFG_STEP, 10'h3ff);
    write_reg(CFG_CENTRE, 10'd512);
    write_reg(CfgSpareLo, 10'h3ff);
    write_reg(CfgSpareHi, 10'h3ff);
    write_reg(CfgSpareLo, 10'h000);
    write_reg(CfgSpareHi, 10'h000);
    run_samples(30);
  endtask

  task automatic test_random_traffic();
    int unsigned idle[4];
    int unsigned stall[4];
    idle = '{0, 56, 0, 18};
    stall = '{0, 0, 56, 18};
    for (int p = 0; p < 8; p++) begin
      set_pacing(idle[p % 4], stall[p % 4]);
      write_reg(CFG_CENTRE, SampleW'($urandom_range(1023)));
      if ($urandom_range(3) == 0) write_reg(CFG_STEP, 10'd255);
      else write_reg(CFG_STEP, SampleW'($urandom_range(40)));
      run_samples(25);
    end
  endtask

  always @(posedge clk) begin
    digit_frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected transfer: seg %h sel %h bar %h last %b",
                   segments, digit_select, bar_pattern, last);
      end else begin
        want = pending_digits.pop_front();
        if (segments !== want.segments || digit_select !== want.digit_select ||
            bar_pattern !== want.bar || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("digit mismatch: expected seg %h sel %h bar %h last %b, got seg %h sel %h bar %h last %b",
                     want.segments, want.digit_select, want.bar, want.last,
                     segments, digit_select, bar_pattern, last);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_digits_and_ladder();
    test_register_extremes();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
